[design/ffca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

   // Table depth and address width.
   localparam int MAX_EXTENTS = 64;
   localparam int ADDR_BITS = 48;
   localparam int IDX_W = $clog2(MAX_EXTENTS);
   localparam int HELD_W = $clog2(MAX_EXTENTS + 1);

   // One free extent as held by a cell.
   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
   } extent_type;

   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_NOFIT = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE = 1'b0,
      CSR_HEAP_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[design/first_fit_coalescing_allocator_core.sv]
// First-fit allocator over an address-ordered table of free extents.
// Requests come in on start/busy: a word (req_kind, req_range_address,
// req_range_size) is taken at a clock edge where start is high and busy and csr_write low.
// The extent table is a ring of 64 cells. Each request turns the ring once,
// one extent past the controller per cycle, which cuts, merges, drops or
// inserts an extent as it goes by.
// A request occupies the block through the walk and a done state; the
// result word then appears on the rsp_ ports for one cycle, marked by
// rsp_valid. The receiver cannot stall; the next request may be accepted
// in the cycle the result is shown, not before.
// Writes on the csr_ port (index 0 heap base, index 1 heap size) are taken
// only while busy is low and rebuild the table as a single extent, or as an empty table when the heap size is zero.
// Synchronous reset empties the table and clears all totals; the result
// outputs show the running totals, hint and extent count at all times.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_coalescing_allocator_core
   import ffca_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_kind,
   input  wire  [47:0] req_range_address,
   input  wire  [47:0] req_range_size,
   output logic        rsp_valid,
   output logic [47:0] rsp_granted_address,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_free_bytes,
   output logic [47:0] rsp_allocated_bytes,
   output logic [47:0] rsp_largest_free_hint,
   output logic [6:0]  rsp_extent_count,
   input  wire         csr_write,
   input  wire         csr_index,
   input  wire  [47:0] csr_wdata
);

   extent_type cell_data [MAX_EXTENTS];
   extent_type tail;
   extent_type load_data;
   logic shift_en;
   logic load_en;

   // Ring of extent cells, the last one fed by the controller.
   for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
      if (k == MAX_EXTENTS - 1) begin : g_last
         ffca_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .load_en   (1'b0),
            .load_data (load_data),
            .next_data (tail),
            .data_out  (cell_data[k])
         );
      end else if (k == 0) begin : g_first
         ffca_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .load_en   (load_en),
            .load_data (load_data),
            .next_data (cell_data[k+1]),
            .data_out  (cell_data[k])
         );
      end else begin : g_mid
         ffca_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .load_en   (1'b0),
            .load_data (load_data),
            .next_data (cell_data[k+1]),
            .data_out  (cell_data[k])
         );
      end
   end

   // Walk sequencer, extent rewriting and running totals.
   ffca_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_kind              (req_kind),
      .req_range_address     (req_range_address),
      .req_range_size        (req_range_size),
      .rsp_valid             (rsp_valid),
      .rsp_granted_address   (rsp_granted_address),
      .rsp_status            (rsp_status),
      .rsp_free_bytes        (rsp_free_bytes),
      .rsp_allocated_bytes   (rsp_allocated_bytes),
      .rsp_largest_free_hint (rsp_largest_free_hint),
      .rsp_extent_count      (rsp_extent_count),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .head                  (cell_data[0]),
      .head_next             (cell_data[1]),
      .shift_en              (shift_en),
      .tail                  (tail),
      .load_en               (load_en),
      .load_data             (load_data)
   );

endmodule

`default_nettype wire

[design/ffca_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffca_cell
   import ffca_pkg::*;
(
   input  wire        clock,
   input  wire        shift_en,
   input  wire        load_en,
   input  extent_type load_data,
   input  extent_type next_data,
   output extent_type data_out
);

   extent_type data_ff;
   extent_type data_in;

   // A cell takes a loaded extent, else its neighbour's when shifting, else keeps its own.
   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

[design/ffca_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffca_ctrl
   import ffca_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire                  req_kind,
   input  wire  [47:0]          req_range_address,
   input  wire  [47:0]          req_range_size,
   output logic                 rsp_valid,
   output logic [47:0]          rsp_granted_address,
   output logic [1:0]           rsp_status,
   output logic [47:0]          rsp_free_bytes,
   output logic [47:0]          rsp_allocated_bytes,
   output logic [47:0]          rsp_largest_free_hint,
   output logic [6:0]           rsp_extent_count,
   input  wire                  csr_write,
   input  wire                  csr_index,
   input  wire  [47:0]          csr_wdata,
   input  extent_type           head,
   input  extent_type           head_next,
   output logic                 shift_en,
   output extent_type           tail,
   output logic                 load_en,
   output extent_type           load_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);
   localparam logic [ADDR_BITS-1:0] ALL_ONES = {ADDR_BITS{1'b1}};

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [ADDR_BITS-1:0] heap_base_ff, heap_base_in;
   logic [ADDR_BITS-1:0] heap_size_ff, heap_size_in;
   logic [ADDR_BITS-1:0] free_ff, free_in;
   logic [ADDR_BITS-1:0] alloc_ff, alloc_in;
   logic [ADDR_BITS-1:0] hint_size_ff, hint_size_in;
   logic [ADDR_BITS-1:0] hint_addr_ff, hint_addr_in;
   logic kind_ff, kind_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;
   logic found_ff, found_in;
   logic ok_ff, ok_in;
   logic fail_ff, fail_in;
   logic ins_ff, ins_in;
   logic drop_ff, drop_in;
   logic ahead_ff, ahead_in;
   logic modnext_ff, modnext_in;
   logic hold_v_ff, hold_v_in;
   extent_type hold_ff, hold_in;
   logic hstop_ff, hstop_in;
   logic [ADDR_BITS-1:0] granted_ff, granted_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_granted_ff, rsp_granted_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic tv, nv, full;
   logic [HELD_W-1:0] idx_wide;
   logic [ADDR_BITS-1:0] range_end;
   logic [ADDR_BITS-1:0] prev_high;
   logic [ADDR_BITS:0] free_sum, alloc_sum;
   extent_type base_word, new_word, out_word;

   // Position of the word at the head relative to the table fill.
   assign idx_wide = HELD_W'(idx_ff);
   assign tv = idx_wide < held_ff;
   assign nv = (idx_wide + HELD_W'(1)) < held_ff;
   assign full = held_ff >= HELD_W'(MAX_EXTENTS);
   assign range_end = addr_ff + size_ff;
   assign prev_high = head.start + head.length;
   assign new_word = '{start: addr_ff, length: size_ff};
   assign free_sum = {1'b0, free_ff} + {1'b0, size_ff};
   assign alloc_sum = {1'b0, alloc_ff} + {1'b0, size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff <= '0;
         heap_base_ff <= '0;
         heap_size_ff <= '0;
         free_ff <= '0;
         alloc_ff <= '0;
         hint_size_ff <= '0;
         hint_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         heap_base_ff <= heap_base_in;
         heap_size_ff <= heap_size_in;
         free_ff <= free_in;
         alloc_ff <= alloc_in;
         hint_size_ff <= hint_size_in;
         hint_addr_ff <= hint_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      size_ff <= size_in;
      found_ff <= found_in;
      ok_ff <= ok_in;
      fail_ff <= fail_in;
      ins_ff <= ins_in;
      drop_ff <= drop_in;
      ahead_ff <= ahead_in;
      modnext_ff <= modnext_in;
      hold_v_ff <= hold_v_in;
      hold_ff <= hold_in;
      hstop_ff <= hstop_in;
      granted_ff <= granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      held_in = held_ff;
      heap_base_in = heap_base_ff;
      heap_size_in = heap_size_ff;
      free_in = free_ff;
      alloc_in = alloc_ff;
      hint_size_in = hint_size_ff;
      hint_addr_in = hint_addr_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      size_in = size_ff;
      found_in = found_ff;
      ok_in = ok_ff;
      fail_in = fail_ff;
      ins_in = ins_ff;
      drop_in = drop_ff;
      ahead_in = ahead_ff;
      modnext_in = 1'b0;
      hold_v_in = hold_v_ff;
      hold_in = hold_ff;
      hstop_in = hstop_ff;
      granted_in = granted_ff;
      rsp_valid_in = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in = rsp_status_ff;
      shift_en = 1'b0;
      load_en = 1'b0;
      load_data = '{start: heap_base_ff, length: heap_size_ff};

      // Word leaving the head, with any change still pending from earlier in the walk.
      base_word = ahead_ff ? head_next : head;
      if (modnext_ff) begin
         base_word = '{start: addr_ff, length: head.length + size_ff};
      end
      if (hold_v_ff) begin
         out_word = hold_ff;
         hold_in = base_word;
      end else begin
         out_word = base_word;
      end

      case (state_ff)
         ST_IDLE: begin
            // Register writes rebuild the table as one extent, or as none when the size is zero.
            if (csr_write) begin
               if (csr_index == CSR_HEAP_BASE) begin
                  heap_base_in = csr_wdata;
               end else begin
                  heap_size_in = csr_wdata;
               end
               load_en = 1'b1;
               load_data = '{start: heap_base_in, length: heap_size_in};
               held_in = (heap_size_in != '0) ? HELD_W'(1) : '0;
               free_in = heap_size_in;
               alloc_in = '0;
               hint_size_in = heap_size_in;
               hint_addr_in = heap_base_in;
            end else if (start) begin
               state_in = ST_WALK;
               idx_in = '0;
               kind_in = req_kind;
               addr_in = req_range_address;
               size_in = req_range_size;
               found_in = 1'b0;
               ok_in = 1'b0;
               fail_in = 1'b0;
               ins_in = 1'b0;
               drop_in = 1'b0;
               ahead_in = 1'b0;
               hold_v_in = 1'b0;
               hstop_in = 1'b0;
               granted_in = '0;
            end
         end

         ST_WALK: begin
            shift_en = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end

            if (kind_ff == KIND_ALLOC) begin
               // First extent long enough is cut or removed.
               if (!found_ff && tv && head.length >= size_ff) begin
                  found_in = 1'b1;
                  ok_in = 1'b1;
                  granted_in = head.start;
                  if (head.length == size_ff) begin
                     drop_in = 1'b1;
                     ahead_in = 1'b1;
                     out_word = head_next;
                  end else begin
                     out_word = '{start: head.start + size_ff,
                                  length: head.length - size_ff};
                     if (hint_addr_ff == head.start) begin
                        hint_size_in = (hint_size_ff > size_ff) ?
                                       hint_size_ff - size_ff : '0;
                        hint_addr_in = head.start + size_ff;
                     end
                  end
               end
            end else begin
               // Lazy raise of the hint over the extents walked.
               if (!hstop_ff && tv) begin
                  if (head.length > hint_size_ff) begin
                     hint_size_in = head.length;
                     hint_addr_in = head.start;
                  end
                  if (addr_ff < head.start) begin
                     hstop_in = 1'b1;
                  end
               end

               if (!found_ff) begin
                  if (held_ff == '0) begin
                     // Release into an empty table.
                     found_in = 1'b1;
                     ok_in = 1'b1;
                     ins_in = 1'b1;
                     out_word = new_word;
                  end else if (idx_ff == '0 && addr_ff < head.start) begin
                     // Range lies below every extent.
                     found_in = 1'b1;
                     if (range_end == head.start) begin
                        ok_in = 1'b1;
                        out_word = '{start: addr_ff, length: head.length + size_ff};
                     end else if (full) begin
                        fail_in = 1'b1;
                     end else begin
                        ok_in = 1'b1;
                        ins_in = 1'b1;
                        out_word = new_word;
                        hold_in = head;
                        hold_v_in = 1'b1;
                     end
                  end else if (tv && (!nv || addr_ff < head_next.start)) begin
                     // Head is the extent below the range.
                     found_in = 1'b1;
                     if (prev_high == addr_ff) begin
                        ok_in = 1'b1;
                        if (nv && head_next.start == range_end) begin
                           out_word = '{start: head.start,
                                        length: head.length + size_ff + head_next.length};
                           ahead_in = 1'b1;
                           drop_in = 1'b1;
                        end else begin
                           out_word = '{start: head.start, length: head.length + size_ff};
                        end
                     end else if (nv && head_next.start == range_end) begin
                        ok_in = 1'b1;
                        modnext_in = 1'b1;
                     end else if (full) begin
                        fail_in = 1'b1;
                     end else begin
                        ok_in = 1'b1;
                        ins_in = 1'b1;
                        hold_in = new_word;
                        hold_v_in = 1'b1;
                     end
                  end
               end
            end
         end

         ST_DONE: begin
            // Totals and table fill follow the outcome of the walk.
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_granted_in = granted_ff;
            rsp_status_in = STATUS_DONE;
            if (ins_ff) begin
               held_in = held_ff + HELD_W'(1);
            end else if (drop_ff) begin
               held_in = held_ff - HELD_W'(1);
            end
            if (kind_ff == KIND_ALLOC) begin
               if (ok_ff) begin
                  free_in = (free_ff > size_ff) ? free_ff - size_ff : '0;
                  alloc_in = alloc_sum[ADDR_BITS] ? ALL_ONES : alloc_sum[ADDR_BITS-1:0];
               end else begin
                  rsp_status_in = STATUS_NOFIT;
               end
            end else begin
               if (fail_ff) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  free_in = free_sum[ADDR_BITS] ? ALL_ONES : free_sum[ADDR_BITS-1:0];
                  alloc_in = (alloc_ff > size_ff) ? alloc_ff - size_ff : '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign tail = out_word;
   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_free_bytes = free_ff;
   assign rsp_allocated_bytes = alloc_ff;
   assign rsp_largest_free_hint = hint_size_ff;
   assign rsp_extent_count = held_ff;

endmodule

`default_nettype wire

[tb/tb_first_fit_coalescing_allocator_core.sv]
`timescale 1ns / 1ps

module tb_first_fit_coalescing_allocator_core;
   import ffca_pkg::*;

   typedef struct packed {
      logic [47:0] granted;
      status_type  status;
      logic [47:0] free_b;
      logic [47:0] alloc_b;
      logic [47:0] hint;
      logic [6:0]  count;
   } outcome_type;

   typedef struct {
      bit            is_cfg;
      csr_index_type idx;
      kind_type      kind;
      logic [47:0]   a;
      logic [47:0]   b;
      bit            typed;
      outcome_type   want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   kind_type    req_kind = KIND_ALLOC;
   logic [47:0] req_range_address = '0;
   logic [47:0] req_range_size = '0;
   logic        rsp_valid;
   logic [47:0] rsp_granted_address;
   logic [1:0]  rsp_status;
   logic [47:0] rsp_free_bytes;
   logic [47:0] rsp_allocated_bytes;
   logic [47:0] rsp_largest_free_hint;
   logic [6:0]  rsp_extent_count;
   logic        csr_write = 1'b0;
   csr_index_type csr_index = CSR_HEAP_BASE;
   logic [47:0] csr_wdata = '0;

   first_fit_coalescing_allocator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_range_address(req_range_address),
      .req_range_size(req_range_size), .rsp_valid(rsp_valid),
      .rsp_granted_address(rsp_granted_address), .rsp_status(rsp_status),
      .rsp_free_bytes(rsp_free_bytes), .rsp_allocated_bytes(rsp_allocated_bytes),
      .rsp_largest_free_hint(rsp_largest_free_hint),
      .rsp_extent_count(rsp_extent_count), .csr_write(csr_write),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the allocator state.
   logic [47:0] sh_start [0:MAX_EXTENTS-1];
   logic [47:0] sh_len [0:MAX_EXTENTS-1];
   int          sh_held;
   logic [47:0] sh_base, sh_size, sh_free, sh_alloc, sh_hint, sh_hint_addr, sh_last_rel;

   outcome_type pending_words[$];
   logic [47:0] live_addr[$];
   logic [47:0] live_size[$];
   int          faults = 0;
   int          words_sent = 0;
   int          words_seen = 0;
   int          full_seen = 0;
   int          nofit_seen = 0;
   int          burst_left = 0;

   function automatic logic [47:0] sat_plus(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
   endfunction

   function automatic logic [47:0] sat_minus(logic [47:0] a, logic [47:0] b);
      return (a > b) ? a - b : 48'd0;
   endfunction

   function automatic void rebuild_table();
      sh_held = 0;
      if (sh_size != 0) begin
         sh_start[0] = sh_base;
         sh_len[0] = sh_size;
         sh_held = 1;
      end
      sh_free = sh_size;
      sh_alloc = '0;
      sh_hint = sh_size;
      sh_hint_addr = sh_base;
      sh_last_rel = '0;
   endfunction

   function automatic void remove_at(int k);
      for (int j = k; j + 1 < sh_held; j++) begin
         sh_start[j] = sh_start[j+1];
         sh_len[j] = sh_len[j+1];
      end
      sh_held--;
   endfunction

   function automatic void insert_at(int k, logic [47:0] s, logic [47:0] l);
      for (int j = sh_held; j > k; j--) begin
         sh_start[j] = sh_start[j-1];
         sh_len[j] = sh_len[j-1];
      end
      sh_start[k] = s;
      sh_len[k] = l;
      sh_held++;
   endfunction

   // Works out the result word of one request and advances the shadow state.
   function automatic outcome_type predict_allocation(kind_type k, logic [47:0] addr,
                                                      logic [47:0] size);
      outcome_type r;
      int          i;
      int          p;
      bit          placed;
      logic [47:0] base, fin, phigh;
      r.granted = '0;
      r.status = STATUS_DONE;
      if (k == KIND_ALLOC) begin
         i = sh_held;
         for (int j = 0; j < sh_held; j++) begin
            if (sh_len[j] >= size) begin
               i = j;
               break;
            end
         end
         if (i >= sh_held) begin
            r.status = STATUS_NOFIT;
         end else begin
            base = sh_start[i];
            if (sh_len[i] == size) begin
               remove_at(i);
            end else begin
               sh_start[i] = base + size;
               sh_len[i] = sh_len[i] - size;
               if (sh_hint_addr == base) begin
                  sh_hint = sat_minus(sh_hint, size);
                  sh_hint_addr = sh_start[i];
               end
            end
            sh_free = sat_minus(sh_free, size);
            sh_alloc = sat_plus(sh_alloc, size);
            r.granted = base;
         end
      end else begin
         fin = addr + size;
         placed = 1'b1;
         if (sh_held == 0) begin
            insert_at(0, addr, size);
         end else begin
            // The walk raises the hint lazily until it finds the place.
            i = sh_held;
            for (int j = 0; j < sh_held; j++) begin
               if (sh_len[j] > sh_hint) begin
                  sh_hint = sh_len[j];
                  sh_hint_addr = sh_start[j];
               end
               if (addr < sh_start[j]) begin
                  i = j;
                  break;
               end
            end
            if (i == 0) begin
               if (fin == sh_start[0]) begin
                  sh_start[0] = addr;
                  sh_len[0] = sh_len[0] + size;
               end else if (sh_held >= MAX_EXTENTS) begin
                  placed = 1'b0;
               end else begin
                  insert_at(0, addr, size);
               end
            end else begin
               p = i - 1;
               phigh = sh_start[p] + sh_len[p];
               if (phigh == addr) begin
                  sh_len[p] = sh_len[p] + size;
                  if (i < sh_held && sh_start[i] == fin) begin
                     sh_len[p] = sh_len[p] + sh_len[i];
                     remove_at(i);
                  end
               end else if (i < sh_held && sh_start[i] == fin) begin
                  sh_start[i] = addr;
                  sh_len[i] = sh_len[i] + size;
               end else if (sh_held >= MAX_EXTENTS) begin
                  placed = 1'b0;
               end else begin
                  insert_at(i, addr, size);
               end
            end
         end
         if (placed) begin
            sh_free = sat_plus(sh_free, size);
            sh_alloc = sat_minus(sh_alloc, size);
            sh_last_rel = size;
         end else begin
            r.status = STATUS_FULL;
         end
      end
      r.free_b = sh_free;
      r.alloc_b = sh_alloc;
      r.hint = sh_hint;
      r.count = sh_held[6:0];
      return r;
   endfunction

   // Result monitor: every strobed word is checked against the oldest expectation.
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (pending_words.size() == 0) begin
            $error("result word with no expectation waiting");
            faults++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_granted_address !== w.granted) begin
               $error("granted_address: expected %h, got %h", w.granted, rsp_granted_address);
               faults++;
            end
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               faults++;
            end
            if (rsp_free_bytes !== w.free_b) begin
               $error("free_bytes: expected %h, got %h", w.free_b, rsp_free_bytes);
               faults++;
            end
            if (rsp_allocated_bytes !== w.alloc_b) begin
               $error("allocated_bytes: expected %h, got %h", w.alloc_b, rsp_allocated_bytes);
               faults++;
            end
            if (rsp_largest_free_hint !== w.hint) begin
               $error("largest_free_hint: expected %h, got %h", w.hint, rsp_largest_free_hint);
               faults++;
            end
            if (rsp_extent_count !== w.count) begin
               $error("extent_count: expected %0d, got %0d", w.count, rsp_extent_count);
               faults++;
            end
         end
      end
   end

   // Presents one request word and returns at the edge that takes it; start stays high.
   task automatic send_request(kind_type k, logic [47:0] a, logic [47:0] s,
                               bit typed, outcome_type want, output outcome_type got);
      req_kind <= k;
      req_range_address <= a;
      req_range_size <= s;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      got = predict_allocation(k, a, s);
      pending_words.push_back(typed ? want : got);
      words_sent++;
      if (got.status == STATUS_FULL) full_seen++;
      if (got.status == STATUS_NOFIT) nofit_seen++;
   endtask

   // Sender pacing: bursts of back-to-back words separated by random gaps.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 7);
      end
   endtask

   // Lowers start and waits until every expected word is back and the block is idle.
   task automatic drain_block();
      start <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [47:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_HEAP_BASE) sh_base = data;
      else sh_size = data;
      rebuild_table();
   endtask

   task automatic random_request(bit wide);
      outcome_type got;
      logic [47:0] a, s;
      int          pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         s = wide ? 48'({$urandom, $urandom} >> $urandom_range(0, 47))
                  : 48'($urandom_range(1, 4096));
         send_request(KIND_ALLOC, 48'({$urandom, $urandom}), s, 1'b0, got, got);
         if (got.status == STATUS_DONE && s != 0) begin
            live_addr.push_back(got.granted);
            live_size.push_back(s);
         end
      end else if (pick < 88 && live_addr.size() != 0) begin
         n = $urandom_range(0, live_addr.size() - 1);
         a = live_addr[n];
         s = live_size[n];
         live_addr.delete(n);
         live_size.delete(n);
         send_request(KIND_RELEASE, a, s, 1'b0, got, got);
      end else begin
         // Noise: arbitrary releases, zero and oversize requests.
         a = 48'({$urandom, $urandom});
         s = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
         if ($urandom_range(0, 3) == 0) s = '0;
         send_request(kind_type'($urandom_range(0, 1)), a, s, 1'b0, got, got);
      end
      pace_sender();
   endtask

   initial begin
      plan_row_type plan[$];
      plan_row_type row;
      outcome_type  got;
      logic [47:0]  base;
      sh_base = '0;
      sh_size = '0;
      rebuild_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset state, extremes, merges, wrap-around and an empty heap.
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 5, 1,
              '{0, STATUS_NOFIT, 0, 0, 0, 0}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 48'h100, 48'h10, 1,
              '{0, STATUS_DONE, 48'h10, 0, 0, 1}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 48'h10, 0, '0};
      plan.push_back(row);
      row = '{1, CSR_HEAP_BASE, KIND_ALLOC, 48'h1000, 0, 0, '0};
      plan.push_back(row);
      row = '{1, CSR_HEAP_SIZE, KIND_ALLOC, 48'h10000, 0, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 0, 1,
              '{48'h1000, STATUS_DONE, 48'h10000, 0, 48'h10000, 1}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 48'h100, 1,
              '{48'h1000, STATUS_DONE, 48'hFF00, 48'h100, 48'hFF00, 1}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 48'h10000, 1,
              '{0, STATUS_NOFIT, 48'hFF00, 48'h100, 48'hFF00, 1}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 48'h200, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 48'h1000, 48'h100, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 48'h1100, 48'h200, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 48'h10000, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, '1, '1, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 0, 48'h1000, 0, '0};
      plan.push_back(row);
      row = '{1, CSR_HEAP_BASE, KIND_ALLOC, 48'hFFFF_FFFF_F000, 0, 0, '0};
      plan.push_back(row);
      row = '{1, CSR_HEAP_SIZE, KIND_ALLOC, '1, 0, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, '1, 48'h2000, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 48'hFFFF_FFFF_F000, 48'h2000, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, '1, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 0, '0};
      plan.push_back(row);
      row = '{1, CSR_HEAP_SIZE, KIND_ALLOC, 0, 0, 0, '0};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_ALLOC, 0, 1, 1,
              '{0, STATUS_NOFIT, 0, 0, 0, 0}};
      plan.push_back(row);
      row = '{0, CSR_HEAP_BASE, KIND_RELEASE, '1, '1, 0, '0};
      plan.push_back(row);

      foreach (plan[r]) begin
         if (plan[r].is_cfg) begin
            drain_block();
            write_register(plan[r].idx, plan[r].a);
         end else begin
            send_request(plan[r].kind, plan[r].b == 0 && plan[r].kind == KIND_ALLOC ?
                         plan[r].a : plan[r].a, plan[r].b, plan[r].typed, plan[r].want, got);
            pace_sender();
         end
      end

      // Fragmentation: carve many small blocks, free every other one until the
      // table fills, then free the rest so that extents merge on both sides.
      drain_block();
      base = 48'({$urandom, $urandom}) & 48'h7FFF_FFFF_0000;
      write_register(CSR_HEAP_BASE, base);
      write_register(CSR_HEAP_SIZE, 48'h10_0000);
      live_addr.delete();
      live_size.delete();
      for (int n = 0; n < 140; n++) begin
         send_request(KIND_ALLOC, 0, 48'(16 * $urandom_range(1, 8)), 1'b0, got, got);
         live_addr.push_back(got.granted);
         live_size.push_back(48'(got.alloc_b - (n == 0 ? 48'd0 : live_size.sum())));
         pace_sender();
      end
      for (int n = 0; n < 140; n += 2) begin
         send_request(KIND_RELEASE, live_addr[n], live_size[n], 1'b0, got, got);
         pace_sender();
      end
      for (int n = 1; n < 140; n += 2) begin
         send_request(KIND_RELEASE, live_addr[n], live_size[n], 1'b0, got, got);
         pace_sender();
      end

      // Random phases with fresh heap settings each time.
      for (int ph = 0; ph < 3; ph++) begin
         drain_block();
         live_addr.delete();
         live_size.delete();
         write_register(CSR_HEAP_BASE, 48'({$urandom, $urandom}));
         write_register(CSR_HEAP_SIZE, ph == 2 ? 48'({$urandom, $urandom})
                                               : 48'($urandom_range(32'h4000, 32'h10_0000)));
         repeat (70) random_request(ph == 2);
      end

      drain_block();
      repeat (80) @(posedge clock);
      $display("Sent %0d request words and checked %0d result words.", words_sent, words_seen);
      $display("Table-full replies: %0d, no-fit replies: %0d.", full_seen, nofit_seen);
      if (faults == 0 && pending_words.size() == 0) begin
         $display("first_fit_coalescing_allocator_core: match");
      end else begin
         $display("first_fit_coalescing_allocator_core: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5ms;
      $display("first_fit_coalescing_allocator_core: mismatch");
      $finish;
   end

endmodule

[filelist.f]
design/ffca_pkg.sv
design/ffca_cell.sv
design/ffca_ctrl.sv
design/first_fit_coalescing_allocator_core.sv
tb/tb_first_fit_coalescing_allocator_core.sv
